@@ rtl/iirdf1_pkg.sv @@
// iirdf1_pkg: shared types and fixed constants of the direct-form-I iir filter
// depends on nothing; used by the filter core
`default_nettype none

package iirdf1_pkg;

   localparam int COEF_WIDTH      = 16;
   localparam int FRAC_SHIFT      = 14;
   localparam int CSR_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int ACC_GUARD       = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_B_TAPS_LOW  = 2'd0,
      CSR_B_TAPS_HIGH = 2'd1,
      CSR_A_TAPS_LOW  = 2'd2,
      CSR_A_TAPS_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MAC    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/iirdf1_if.sv @@
// iirdf1_if: valid/ready channels carrying request samples in and filtered samples out
// depends on nothing; used by the filter core ports
`default_nettype none

interface iirdf1_req_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirdf1_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ rtl/iir_filter_direct_form_one_core.sv @@
// iir_filter_direct_form_one_core: direct-form-I iir filter on one shared multiply-accumulate
// depends on iirdf1_pkg and the channel interfaces in iirdf1_if.sv
//
//   channel   direction   handshake         payload
//   req_if    in          valid / ready     sample_in   (SAMPLE_WIDTH, signed Q3.12)
//   rsp_if    out         valid / ready     sample_out  (SAMPLE_WIDTH, signed Q3.12)
//   csr_*     in          csr_wr_en only    csr_index, csr_wdata (64 bits)
//
// one request runs from one acceptance to the next through one accept step,
// 2*TAPS-1 passes through the single multiplier, one drain add and one round/saturate step;
// the multiplier with its product register sets this sequence
// reset is synchronous and clears coefficients, both histories and the control state
// a finished result waits in the output register; a new request is taken meanwhile, but the
// round/saturate step holds until that register has been emptied
`default_nettype none

module iir_filter_direct_form_one_core #(
   parameter int TAPS         = 6,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   iirdf1_req_if.sink                               req_if,
   iirdf1_rsp_if.source                             rsp_if,
   input  logic                                     csr_wr_en,
   input  logic [iirdf1_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [iirdf1_pkg::CSR_WIDTH-1:0]         csr_wdata
);

   localparam int CW         = iirdf1_pkg::COEF_WIDTH;
   localparam int PROD_W     = SAMPLE_WIDTH + CW;
   localparam int ACC_W      = PROD_W + iirdf1_pkg::ACC_GUARD;
   localparam int HIST_DEPTH = TAPS - 1;
   localparam int KW         = $clog2(TAPS);
   localparam int HW         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam logic [KW-1:0] LAST_K = KW'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(1) << (iirdf1_pkg::FRAC_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      signed'({{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   // coefficient registers
   logic [iirdf1_pkg::CSR_WIDTH-1:0] b_low_ff, b_high_ff, a_low_ff, a_high_ff;
   logic [2*iirdf1_pkg::CSR_WIDTH-1:0] b_vec, a_vec;

   // sequencer and datapath
   iirdf1_pkg::state_type            state_ff, state_in;
   logic [KW-1:0]                    k_ff, k_in;
   logic                             fb_ff, fb_in;
   logic                             pv_ff, pv_in;
   logic                             neg_ff, neg_in;
   logic signed [SAMPLE_WIDTH-1:0]   x_ff, x_in;
   logic signed [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0]   xh_ff [HIST_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0]   xh_in [HIST_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0]   yh_ff [HIST_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0]   yh_in [HIST_DEPTH];
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]   out_ff, out_in;

   logic                             req_accept;
   logic                             load;
   logic [KW-1:0]                    kminus1;
   logic [HW-1:0]                    hidx;
   logic signed [CW-1:0]             op_coef;
   logic signed [SAMPLE_WIDTH-1:0]   op_smp;
   logic signed [ACC_W-1:0]          shifted;
   logic signed [SAMPLE_WIDTH-1:0]   y_sat;

   assign b_vec = {b_high_ff, b_low_ff};
   assign a_vec = {a_high_ff, a_low_ff};

   assign req_if.ready      = (state_ff == iirdf1_pkg::ST_IDLE);
   assign req_accept        = req_if.valid && req_if.ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = out_ff;
   assign load = (state_ff == iirdf1_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_low_ff  <= '0;
         b_high_ff <= '0;
         a_low_ff  <= '0;
         a_high_ff <= '0;
      end else if (csr_wr_en) begin
         case (iirdf1_pkg::csr_index_type'(csr_index))
            iirdf1_pkg::CSR_B_TAPS_LOW:  b_low_ff  <= csr_wdata;
            iirdf1_pkg::CSR_B_TAPS_HIGH: b_high_ff <= csr_wdata;
            iirdf1_pkg::CSR_A_TAPS_LOW:  a_low_ff  <= csr_wdata;
            iirdf1_pkg::CSR_A_TAPS_HIGH: a_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      kminus1 = k_ff - KW'(1);
      hidx    = kminus1[HW-1:0];
      if (fb_ff) begin
         op_coef = signed'(a_vec[kminus1*CW +: CW]);
         op_smp  = yh_ff[hidx];
      end else begin
         op_coef = signed'(b_vec[k_ff*CW +: CW]);
         if (k_ff == '0) begin
            op_smp = x_ff;
         end else begin
            op_smp = xh_ff[hidx];
         end
      end
   end

   // round already folded into the accumulator start value
   always_comb begin
      shifted = acc_ff >>> iirdf1_pkg::FRAC_SHIFT;
      if (shifted > SAT_MAX) begin
         y_sat = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_MIN) begin
         y_sat = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         y_sat = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      fb_in        = fb_ff;
      pv_in        = 1'b0;
      neg_in       = fb_ff;
      x_in         = x_ff;
      prod_in      = PROD_W'(op_coef) * PROD_W'(op_smp);
      acc_in       = acc_ff;
      xh_in        = xh_ff;
      yh_in        = yh_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pv_ff) begin
         if (neg_ff) begin
            acc_in = acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end

      case (state_ff)
         iirdf1_pkg::ST_IDLE: begin
            if (req_accept) begin
               x_in     = req_if.sample_in;
               k_in     = '0;
               fb_in    = 1'b0;
               acc_in   = ROUND_HALF;
               state_in = iirdf1_pkg::ST_MAC;
            end
         end
         iirdf1_pkg::ST_MAC: begin
            pv_in = 1'b1;
            if (fb_ff && (k_ff == LAST_K)) begin
               state_in = iirdf1_pkg::ST_DRAIN;
            end else if (!fb_ff && (k_ff != '0)) begin
               fb_in = 1'b1;
            end else begin
               fb_in = 1'b0;
               k_in  = k_ff + KW'(1);
            end
         end
         iirdf1_pkg::ST_DRAIN: begin
            state_in = iirdf1_pkg::ST_FINISH;
         end
         iirdf1_pkg::ST_FINISH: begin
            if (load) begin
               out_in       = y_sat;
               rsp_valid_in = 1'b1;
               for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                  xh_in[i] = xh_ff[i-1];
                  yh_in[i] = yh_ff[i-1];
               end
               xh_in[0] = x_ff;
               yh_in[0] = y_sat;
               state_in = iirdf1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iirdf1_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iirdf1_pkg::ST_IDLE;
         k_ff         <= '0;
         fb_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         fb_ff        <= fb_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         xh_ff        <= xh_in;
         yh_ff        <= yh_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   // sequencer checks
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == iirdf1_pkg::ST_MAC) && (k_ff == '0) && !fb_ff)
      else $error("sequencer did not start at tap zero");

   a_fb_tap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iirdf1_pkg::ST_MAC) && fb_ff |-> (k_ff != '0) && (k_ff <= LAST_K))
      else $error("feedback pass on an invalid tap");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iirdf1_pkg::ST_DRAIN) |-> $past(fb_ff) && ($past(k_ff) == LAST_K))
      else $error("drain entered before the last product");

   a_history: assert property (@(posedge clock) disable iff (reset)
      load |=> (xh_ff[0] == $past(x_ff)) && rsp_valid_ff)
      else $error("history not updated with the result");

endmodule

`default_nettype wire
